>>> src/uwn_pkg.sv
// shared types, byte codes and character classing for the whitespace normalizer
package uwn_pkg;

	localparam int UWN_QDEPTH = 4;

	localparam logic [7:0] BYTE_NUL   = 8'h00;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_TAB   = 8'h09;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_C2    = 8'hC2;
	localparam logic [7:0] BYTE_E1    = 8'hE1;
	localparam logic [7:0] BYTE_E2    = 8'hE2;
	localparam logic [7:0] BYTE_E3    = 8'hE3;
	localparam logic [7:0] BYTE_80    = 8'h80;
	localparam logic [7:0] BYTE_81    = 8'h81;
	localparam logic [7:0] BYTE_85    = 8'h85;
	localparam logic [7:0] BYTE_8A    = 8'h8A;
	localparam logic [7:0] BYTE_8E    = 8'h8E;
	localparam logic [7:0] BYTE_9A    = 8'h9A;
	localparam logic [7:0] BYTE_9F    = 8'h9F;
	localparam logic [7:0] BYTE_A0    = 8'hA0;
	localparam logic [7:0] BYTE_A8    = 8'hA8;
	localparam logic [7:0] BYTE_A9    = 8'hA9;
	localparam logic [7:0] BYTE_AF    = 8'hAF;

	localparam logic REG_TRIM_INNER = 1'b0;

	// one queued job for the output side
	typedef struct packed {
		logic        space;
		logic [2:0]  nbytes;
		logic [31:0] data;
		logic        term;
	} cmd_t;

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd1;
		if (b >= 8'hC0 && b <= 8'hDF) len = 3'd2;
		if (b >= 8'hE0 && b <= 8'hEF) len = 3'd3;
		if (b >= 8'hF0 && b <= 8'hF7) len = 3'd4;
		return len;
	endfunction

	function automatic logic is_white(input logic [31:0] c, input logic [2:0] k);
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		logic       w;
		c0 = c[7:0];
		c1 = c[15:8];
		c2 = c[23:16];
		w  = 1'b0;
		case (k)
			3'd1: w = (c0 >= BYTE_TAB && c0 <= BYTE_CR) || c0 == BYTE_SPACE;
			3'd2: w = c0 == BYTE_C2 && (c1 == BYTE_85 || c1 == BYTE_A0);
			3'd3: begin
				if (c0 == BYTE_E1)
					w = (c1 == BYTE_9A && c2 == BYTE_80) || (c1 == BYTE_A0 && c2 == BYTE_8E);
				else if (c0 == BYTE_E2) begin
					if (c1 == BYTE_80)
						w = (c2 >= BYTE_80 && c2 <= BYTE_8A) || c2 == BYTE_A8 ||
						    c2 == BYTE_A9 || c2 == BYTE_AF;
					else if (c1 == BYTE_81)
						w = c2 == BYTE_9F;
				end else if (c0 == BYTE_E3)
					w = c1 == BYTE_80 && c2 == BYTE_80;
			end
			default: w = 1'b0;
		endcase
		return w;
	endfunction

endpackage

>>> src/uwn_front.sv
// input side: gathers characters, classes them and issues output jobs
module uwn_front
	import uwn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       trim_inner,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       q_full,
	output logic       in_ready,
	output logic       push,
	output cmd_t       push_cmd
);

	logic [23:0] char_bytes_q;
	logic [2:0]  bytes_expected_q;
	logic [1:0]  bytes_held_q;
	logic        seen_text_q;
	logic        space_pending_q;
	logic        string_ended_q;

	logic [23:0] char_bytes_d;
	logic [2:0]  bytes_expected_d;
	logic [1:0]  bytes_held_d;
	logic        seen_text_d;
	logic        space_pending_d;
	logic        string_ended_d;

	logic [31:0] cdata;
	logic [2:0]  expected;
	logic [2:0]  knew;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// place the new byte after the bytes already held
	always_comb begin
		cdata = {8'h00, char_bytes_q};
		case (bytes_held_q)
			2'd0: cdata[7:0]   = in_byte;
			2'd1: cdata[15:8]  = in_byte;
			2'd2: cdata[23:16] = in_byte;
			default: cdata[31:24] = in_byte;
		endcase
	end

	assign expected = (bytes_held_q == 2'd0) ? lead_length(in_byte) : bytes_expected_q;
	assign knew     = {1'b0, bytes_held_q} + 3'd1;

	always_comb begin
		char_bytes_d     = char_bytes_q;
		bytes_expected_d = bytes_expected_q;
		bytes_held_d     = bytes_held_q;
		seen_text_d      = seen_text_q;
		space_pending_d  = space_pending_q;
		string_ended_d   = string_ended_q;
		push_cmd         = '0;
		if (string_ended_q) begin
			if (in_last) string_ended_d = 1'b0;
		end else if (in_byte == BYTE_NUL) begin
			push_cmd.term    = 1'b1;
			char_bytes_d     = '0;
			bytes_expected_d = '0;
			bytes_held_d     = '0;
			seen_text_d      = 1'b0;
			space_pending_d  = 1'b0;
			string_ended_d   = !in_last;
		end else begin
			if (knew < expected) begin
				char_bytes_d     = cdata[23:0];
				bytes_held_d     = knew[1:0];
				bytes_expected_d = expected;
			end else begin
				if (is_white(cdata, knew)) begin
					if (seen_text_q) space_pending_d = 1'b1;
				end else begin
					push_cmd.space  = space_pending_q && !trim_inner;
					push_cmd.nbytes = knew;
					push_cmd.data   = cdata;
					space_pending_d = 1'b0;
					seen_text_d     = 1'b1;
				end
				char_bytes_d     = '0;
				bytes_held_d     = '0;
				bytes_expected_d = '0;
			end
			if (in_last) begin
				push_cmd.term    = 1'b1;
				char_bytes_d     = '0;
				bytes_expected_d = '0;
				bytes_held_d     = '0;
				seen_text_d      = 1'b0;
				space_pending_d  = 1'b0;
				string_ended_d   = 1'b0;
			end
		end
	end

	// only items that give results reach the queue
	assign push = accept && (push_cmd.term || push_cmd.nbytes != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_bytes_q     <= '0;
			bytes_expected_q <= '0;
			bytes_held_q     <= '0;
			seen_text_q      <= 1'b0;
			space_pending_q  <= 1'b0;
			string_ended_q   <= 1'b0;
		end else if (accept) begin
			char_bytes_q     <= char_bytes_d;
			bytes_expected_q <= bytes_expected_d;
			bytes_held_q     <= bytes_held_d;
			seen_text_q      <= seen_text_d;
			space_pending_q  <= space_pending_d;
			string_ended_q   <= string_ended_d;
		end
	end

endmodule

>>> src/uwn_queue.sv
// short job queue between the input and output sides
module uwn_queue
	import uwn_pkg::*;
#(
	parameter int QDepth = UWN_QDEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int CntW = $clog2(QDepth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(QDepth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(QDepth);

	cmd_t            entries_q [QDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = count_q == CntFull;
	assign head_valid = count_q != '0;
	assign head_cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntFull) else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q)) else $error("pointers apart when empty");

endmodule

>>> src/uwn_back.sv
// output side: turns each job into a run of result bytes
module uwn_back
	import uwn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cmd_t       head_cmd,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       pop
);

	logic [2:0] pos_q;
	logic [2:0] total;
	logic [2:0] idx;
	logic       at_space;
	logic       take;

	assign total    = {2'b00, head_cmd.space} + head_cmd.nbytes + {2'b00, head_cmd.term};
	assign at_space = head_cmd.space && pos_q == 3'd0;
	assign idx      = pos_q - {2'b00, head_cmd.space};

	always_comb begin
		out_byte = BYTE_NUL;
		out_last = 1'b0;
		if (at_space)
			out_byte = BYTE_SPACE;
		else if (idx < head_cmd.nbytes) begin
			case (idx[1:0])
				2'd0: out_byte = head_cmd.data[7:0];
				2'd1: out_byte = head_cmd.data[15:8];
				2'd2: out_byte = head_cmd.data[23:16];
				default: out_byte = head_cmd.data[31:24];
			endcase
		end else
			out_last = 1'b1;
	end

	assign out_valid = head_valid;
	assign take      = out_valid && out_ready;
	assign pop       = take && (pos_q == total - 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pos_q <= '0;
		else if (pop)
			pos_q <= '0;
		else if (take)
			pos_q <= pos_q + 3'd1;
	end

endmodule

>>> src/utf8_whitespace_normalizer.sv
// top level of the utf-8 whitespace normalizer with its register port
// a result item for an accepted byte is written into the queue and can show from the next cycle on
// throughput: one input byte per cycle while the job queue has room; results leave at one
// item per cycle while m_tready is high, so a character with a leading space or a terminator
// holds the output side for up to six items and the queue absorbs it
// reset: arst_n clears all string state, the queue and trim_inner at once
module utf8_whitespace_normalizer
	import uwn_pkg::*;
#(
	parameter int QDepth = UWN_QDEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // in_last
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,   // out_last
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic trim_inner_q;
	logic cfg_write;

	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	// register file: one register, trim_inner at byte address 0
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_TRIM_INNER) ? {31'd0, trim_inner_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			trim_inner_q <= 1'b0;
		else if (cfg_write && paddr[2] == REG_TRIM_INNER)
			trim_inner_q <= pwdata[0];
	end

	// front gathers and classes characters, issues one job per result-bearing item
	uwn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.trim_inner (trim_inner_q),
		.in_valid   (s_tvalid),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.q_full     (q_full),
		.in_ready   (s_tready),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// registered queue decouples the two sides
	uwn_queue #(
		.QDepth (QDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// back sends optional space, character bytes and terminator one item per cycle while m_tready is high
	uwn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_byte   (m_tdata),
		.out_last   (m_tlast),
		.pop        (pop)
	);

endmodule
